// ----- hw/rtl/dnle_pkg.sv -----
package dnle_pkg;

  localparam int unsigned DEF_MAX_OUTPUT = 512;
  localparam int unsigned DEF_MAX_LABEL  = 255;
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam int unsigned CFG_W       = 10;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned OUT_OFF_W   = 9;
  // covers offsets for the whole MAX_OUTPUT range (up to 4096)
  localparam int unsigned ENTRY_OFF_W = 12;

  localparam logic [CFG_W-1:0]  LIMIT_RESET = 10'd256;
  localparam logic [CHAR_W-1:0] DOT_CHAR    = 8'd46;
  localparam logic [CHAR_W-1:0] NUL_CHAR    = 8'd0;

  typedef enum logic [3:0] {
    K_CHAR = 4'b0001,
    K_LEN  = 4'b0010,
    K_END  = 4'b0100,
    K_ERR  = 4'b1000
  } kind_t;

  // one queued command; K_END expands to two output transactions
  typedef struct packed {
    kind_t                  kind;
    logic [ENTRY_OFF_W-1:0] off;
    logic [ENTRY_OFF_W-1:0] off2;
    logic [CHAR_W-1:0]      data;
  } entry_t;

endpackage

// ----- hw/rtl/dnle_front.sv -----
module dnle_front #(
  parameter int unsigned MAX_OUTPUT = dnle_pkg::DEF_MAX_OUTPUT,
  parameter int unsigned MAX_LABEL  = dnle_pkg::DEF_MAX_LABEL
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [dnle_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         in_valid,
  input  logic [dnle_pkg::CHAR_W-1:0]  in_char,
  output logic                         in_stall,
  input  logic                         q_full,
  output logic                         push,
  output dnle_pkg::entry_t             push_entry
);
  import dnle_pkg::*;

  localparam int unsigned SPACE_W = $clog2(MAX_OUTPUT);
  localparam logic [SPACE_W-1:0] SPACE_RST =
    (MAX_OUTPUT < 256) ? SPACE_W'(MAX_OUTPUT - 1) : SPACE_W'(255);

  logic [CFG_W-1:0]   limit_r;
  logic [SPACE_W-1:0] start_r, start_nxt;
  logic [7:0]         len_r, len_nxt;
  logic [SPACE_W-1:0] space_r, space_nxt;
  logic               failed_r, failed_nxt;

  logic [SPACE_W-1:0] lim_m1;
  logic [8:0]         n;
  logic               full_err;
  logic               char_err;
  logic               accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // effective limit minus one; limit 0 acts as 1, large values clamp
  always_comb begin
    if (limit_r == '0) begin
      lim_m1 = '0;
    end else if (32'(limit_r) > MAX_OUTPUT) begin
      lim_m1 = SPACE_W'(MAX_OUTPUT - 1);
    end else begin
      lim_m1 = SPACE_W'(limit_r - 1'b1);
    end
  end

  assign n        = 9'(len_r) + 9'd1;
  assign full_err = 32'(space_r) <= 32'(len_r);
  assign char_err = (32'(n) > MAX_LABEL) || (32'(space_r) <= 32'(n));

  always_comb begin
    start_nxt  = start_r;
    len_nxt    = len_r;
    space_nxt  = space_r;
    failed_nxt = failed_r;
    push       = 1'b0;
    push_entry.kind = K_ERR;
    push_entry.off  = '0;
    push_entry.off2 = '0;
    push_entry.data = '0;
    if (accept) begin
      if (in_char == NUL_CHAR) begin
        if (!failed_r) begin
          push = 1'b1;
          if (full_err) begin
            push_entry.kind = K_ERR;
          end else begin
            push_entry.kind = K_END;
            push_entry.off  = ENTRY_OFF_W'(start_r);
            push_entry.off2 = ENTRY_OFF_W'(start_r) + ENTRY_OFF_W'(len_r) + 1'b1;
            push_entry.data = len_r;
          end
        end
        start_nxt  = '0;
        len_nxt    = '0;
        space_nxt  = lim_m1;
        failed_nxt = 1'b0;
      end else if (!failed_r) begin
        push = 1'b1;
        if (in_char == DOT_CHAR) begin
          if (full_err) begin
            push_entry.kind = K_ERR;
            failed_nxt      = 1'b1;
          end else begin
            push_entry.kind = K_LEN;
            push_entry.off  = ENTRY_OFF_W'(start_r);
            push_entry.data = len_r;
            start_nxt = start_r + SPACE_W'(len_r) + 1'b1;
            space_nxt = space_r - SPACE_W'(len_r) - 1'b1;
            len_nxt   = '0;
          end
        end else begin
          if (char_err) begin
            push_entry.kind = K_ERR;
            failed_nxt      = 1'b1;
          end else begin
            push_entry.kind = K_CHAR;
            push_entry.off  = ENTRY_OFF_W'(start_r) + ENTRY_OFF_W'(n);
            push_entry.data = in_char;
            len_nxt = n[7:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RESET;
      start_r  <= '0;
      len_r    <= '0;
      space_r  <= SPACE_RST;
      failed_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
      start_r  <= start_nxt;
      len_r    <= len_nxt;
      space_r  <= space_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

// ----- hw/rtl/dnle_fifo.sv -----
module dnle_fifo #(
  parameter int unsigned DEPTH = dnle_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dnle_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output dnle_pkg::entry_t  head,
  output logic              empty
);
  import dnle_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = count_r == CNT_W'(DEPTH);
  assign empty = count_r == '0;
  assign head  = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/dnle_back.sv -----
module dnle_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dnle_pkg::entry_t                head,
  input  logic                            q_empty,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dnle_pkg::OUT_OFF_W-1:0]  out_offset,
  output logic [dnle_pkg::CHAR_W-1:0]     out_byte,
  output logic                            out_last,
  output logic                            out_error
);
  import dnle_pkg::*;

  logic                   valid_r, valid_nxt;
  logic [OUT_OFF_W-1:0]   off_r, off_nxt;
  logic [CHAR_W-1:0]      byte_r, byte_nxt;
  logic                   last_r, last_nxt;
  logic                   err_r, err_nxt;
  logic                   pend_r, pend_nxt;
  logic [OUT_OFF_W-1:0]   pend_off_r, pend_off_nxt;
  logic                   load;

  assign load = !valid_r || !out_stall;

  always_comb begin
    pop          = 1'b0;
    valid_nxt    = valid_r;
    off_nxt      = off_r;
    byte_nxt     = byte_r;
    last_nxt     = last_r;
    err_nxt      = err_r;
    pend_nxt     = pend_r;
    pend_off_nxt = pend_off_r;
    if (load) begin
      if (pend_r) begin
        // second half of a name end: terminating zero
        valid_nxt = 1'b1;
        off_nxt   = pend_off_r;
        byte_nxt  = '0;
        last_nxt  = 1'b1;
        err_nxt   = 1'b0;
        pend_nxt  = 1'b0;
      end else if (!q_empty) begin
        pop       = 1'b1;
        valid_nxt = 1'b1;
        off_nxt   = head.off[OUT_OFF_W-1:0];
        byte_nxt  = head.data;
        last_nxt  = 1'b0;
        err_nxt   = 1'b0;
        unique case (head.kind) inside
          K_CHAR, K_LEN: begin
          end
          K_END: begin
            pend_nxt     = 1'b1;
            pend_off_nxt = head.off2[OUT_OFF_W-1:0];
          end
          K_ERR: begin
            off_nxt  = '0;
            byte_nxt = '0;
            last_nxt = 1'b1;
            err_nxt  = 1'b1;
          end
          default: begin
          end
        endcase
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r      <= off_nxt;
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    err_r      <= err_nxt;
    pend_off_r <= pend_off_nxt;
  end

  assign out_valid  = valid_r;
  assign out_offset = off_r;
  assign out_byte   = byte_r;
  assign out_last   = last_r;
  assign out_error  = err_r;

endmodule

// ----- hw/rtl/dns_name_label_encoder.sv -----
// Channel  Direction  Ports                                          Handshake
// cfg      in         cfg_we, cfg_data                               write on cfg_we
// in       in         in_name_char                                   in_valid / in_stall
// out      out        out_offset, out_byte, out_last, out_error      out_valid / out_stall
//
// One character is accepted per cycle while in_stall is low; each accepted
// character that yields a command goes through the command queue to the output register.
// An ending zero that fits produces two output transactions; a four-entry
// command queue absorbs that and output stalls.
// in_stall is high only while the command queue is full.
// Reset is synchronous (rst_n low) and restores output_limit to 256.
module dns_name_label_encoder #(
  parameter int unsigned MAX_OUTPUT = dnle_pkg::DEF_MAX_OUTPUT,
  parameter int unsigned MAX_LABEL  = dnle_pkg::DEF_MAX_LABEL
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dnle_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dnle_pkg::CHAR_W-1:0]     in_name_char,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dnle_pkg::OUT_OFF_W-1:0]  out_offset,
  output logic [dnle_pkg::CHAR_W-1:0]     out_byte,
  output logic                            out_last,
  output logic                            out_error
);
  import dnle_pkg::*;

  logic   q_full, q_empty, push, pop;
  entry_t push_entry, head;

  dnle_front #(
    .MAX_OUTPUT (MAX_OUTPUT),
    .MAX_LABEL  (MAX_LABEL)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_char    (in_name_char),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  dnle_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty)
  );

  dnle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_offset (out_offset),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .out_error  (out_error)
  );

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last && out_offset == '0 && out_byte == '0)
    else $error("error transaction with nonzero payload");

  a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && !out_error |-> out_byte == '0)
    else $error("terminating transaction carries nonzero byte");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("push into full command queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

endmodule

// ----- tb/tb_dns_name_label_encoder.sv -----
module tb_dns_name_label_encoder;
  import dnle_pkg::*;

  typedef struct {
    logic [OUT_OFF_W-1:0] offset;
    logic [CHAR_W-1:0]    data;
    logic                 last;
    logic                 err;
  } enc_byte_t;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  localparam int N_PHASES  = 11;
  localparam int HOLD_CYC  = 80;
  localparam int SETTLE    = 10;

  // Tracks the encoder state and the queue of bytes it must still emit.
  class label_scoreboard;
    enc_byte_t        expected_q[$];
    logic [CFG_W-1:0] limit_reg;
    int               label_start;
    int               label_len;
    int               room;
    bit               failed;
    int               errors;

    function new();
      limit_reg = LIMIT_RESET;
      errors = 0;
      restart();
    endfunction

    function void set_limit(logic [CFG_W-1:0] v);
      limit_reg = v;
    endfunction

    // limit only takes effect at the start of a name
    function void restart();
      int eff;
      eff = int'(limit_reg);
      if (eff < 1) eff = 1;
      if (eff > DEF_MAX_OUTPUT) eff = DEF_MAX_OUTPUT;
      label_start = 0;
      label_len = 0;
      room = eff - 1;
      failed = 1'b0;
    endfunction

    function void expect_byte(int off, int data, bit last, bit err);
      enc_byte_t e;
      e.offset = off[OUT_OFF_W-1:0];
      e.data = data[CHAR_W-1:0];
      e.last = last;
      e.err = err;
      expected_q.push_back(e);
    endfunction

    function void raise_error();
      failed = 1'b1;
      expect_byte(0, 0, 1'b1, 1'b1);
    endfunction

    function void note_char(logic [CHAR_W-1:0] ch);
      if (ch == NUL_CHAR) begin
        if (!failed) begin
          if (room <= label_len) begin
            raise_error();
          end else begin
            expect_byte(label_start, label_len, 1'b0, 1'b0);
            expect_byte(label_start + label_len + 1, 0, 1'b1, 1'b0);
          end
        end
        restart();
      end else if (!failed) begin
        if (ch == DOT_CHAR) begin
          if (room <= label_len) begin
            raise_error();
          end else begin
            expect_byte(label_start, label_len, 1'b0, 1'b0);
            label_start += label_len + 1;
            room -= label_len + 1;
            label_len = 0;
          end
        end else if (label_len + 1 > DEF_MAX_LABEL || room <= label_len + 1) begin
          raise_error();
        end else begin
          expect_byte(label_start + label_len + 1, int'(ch), 1'b0, 1'b0);
          label_len++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    task check_result(logic [OUT_OFF_W-1:0] offset, logic [CHAR_W-1:0] data,
                      logic last, logic err);
      enc_byte_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected transaction off=%0d byte=%0d last=%0b err=%0b",
                         offset, data, last, err));
      end else begin
        want = expected_q.pop_front();
        if (offset !== want.offset || data !== want.data ||
            last !== want.last || err !== want.err)
          report($sformatf("got off=%0d byte=%0d last=%0b err=%0b, want %0d %0d %0b %0b",
                           offset, data, last, err,
                           want.offset, want.data, want.last, want.err));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CHAR_W-1:0]    in_name_char = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OUT_OFF_W-1:0] out_offset;
  logic [CHAR_W-1:0]    out_byte;
  logic                 out_last;
  logic                 out_error;

  label_scoreboard   sb;
  logic [CHAR_W-1:0] name_buf[$];
  int                n_accepted = 0;
  int                burst_left = 0;
  bit                no_gaps = 1'b0;
  bit                hold_request = 1'b0;

  dns_name_label_encoder i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_name_char (in_name_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_offset   (out_offset),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_error    (out_error)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_offset, out_byte, out_last, out_error);
  end

  // receiver: stall pattern switches among free, random, periodic and heavy modes; one long hold on request
  initial begin
    rx_mode_t mode;
    int       left;
    int       hold_cnt;
    int       cyc;
    mode = RX_FREE;
    left = 0;
    hold_cnt = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_cnt = HOLD_CYC;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(8, 40);
        end
        left--;
        case (mode)
          RX_FREE:     out_stall <= 1'b0;
          RX_RANDOM:   out_stall <= 1'($urandom_range(0, 1));
          RX_PERIODIC: out_stall <= (cyc % 3 == 0);
          default:     out_stall <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] ch);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_name_char <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_char(ch);
    n_accepted++;
  endtask

  task automatic send_name();
    foreach (name_buf[i]) send_char(name_buf[i]);
  endtask

  // dropped characters after an error leave nothing to wait on, so settle a bit more
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(v);
  endtask

  function automatic logic [CHAR_W-1:0] label_char();
    logic [CHAR_W-1:0] c;
    c = CHAR_W'($urandom_range(1, 255));
    if (c == DOT_CHAR) c = c + 1'b1;
    return c;
  endfunction

  task automatic build_random_name();
    int n_labels;
    int len;
    int r;
    name_buf.delete();
    if ($urandom_range(0, 9) < 2) begin
      // noise: dots, stray zeros and arbitrary bytes
      len = $urandom_range(0, 12);
      repeat (len) begin
        r = $urandom_range(0, 3);
        name_buf.push_back(r == 0 ? DOT_CHAR : CHAR_W'($urandom_range(0, 255)));
      end
    end else begin
      n_labels = $urandom_range(0, 4);
      for (int i = 0; i < n_labels; i++) begin
        if (i > 0) name_buf.push_back(DOT_CHAR);
        r = $urandom_range(0, 9);
        if (r < 6) len = $urandom_range(1, 8);
        else if (r < 9) len = $urandom_range(0, 20);
        else len = $urandom_range(21, 60);
        repeat (len) name_buf.push_back(label_char());
      end
      if ($urandom_range(0, 7) == 0) name_buf.push_back(DOT_CHAR);
    end
    name_buf.push_back(NUL_CHAR);
  endtask

  initial begin
    logic [CFG_W-1:0] limits[N_PHASES];
    int               target;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty name, root label, empty labels in the middle, trailing dot
    send_char(NUL_CHAR);
    send_char(DOT_CHAR);
    send_char(NUL_CHAR);
    send_char(8'hFF);
    send_char(DOT_CHAR);
    send_char(DOT_CHAR);
    send_char(8'h01);
    send_char(NUL_CHAR);
    send_char(8'h41);
    send_char(DOT_CHAR);
    send_char(NUL_CHAR);
    wait_idle();

    // tiny output area: full on a character, exact fit, full after a dot
    write_limit(10'd2);
    send_char(NUL_CHAR);
    send_char(8'h61);
    send_char(NUL_CHAR);
    send_char(NUL_CHAR);
    send_char(DOT_CHAR);
    send_char(8'h62);
    send_char(NUL_CHAR);
    wait_idle();

    // limit 0 acts as 1: full on a dot and on the ending zero
    write_limit(10'd0);
    send_char(NUL_CHAR);
    send_char(DOT_CHAR);
    send_char(NUL_CHAR);
    send_char(NUL_CHAR);

    limits = '{10'd1023, 10'd1, 10'd3, 10'd7, 10'd16, 10'd40, 10'd512, 10'd513,
               10'd0, 10'd0, 10'd256};
    limits[8] = CFG_W'($urandom_range(0, 1023));
    limits[9] = CFG_W'($urandom_range(2, 64));

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      write_limit(limits[ph]);
      no_gaps = (ph % 3 == 0);
      if (ph == 6) hold_request = 1'b1;
      target = n_accepted + 28;
      if (ph == 0) begin
        // first name still runs under the old limit; the next has the full area
        build_random_name();
        send_name();
        name_buf.delete();
        repeat (DEF_MAX_LABEL + 2) name_buf.push_back(label_char());
        name_buf.push_back(NUL_CHAR);
        send_name();
      end
      while (n_accepted < target) begin
        build_random_name();
        send_name();
      end
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
